// ----- sv/fdfc_pkg.sv -----
// Package for the flood duplicate filter cache.
// Holds default sizes, field widths, controller state and control structs.
// No dependencies.
package fdfc_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int STAMP_BITS_DEF    = 32;
  localparam int IN_W              = 32;
  localparam int SLOT_W            = 4;
  localparam int OUT_DATA_W        = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// ----- sv/fdfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fdfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/fdfc_ctrl.sv -----
// Controller state machine for the flood duplicate filter cache.
// Depends on fdfc_pkg.
module fdfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  fdfc_pkg::status_t status,
  output fdfc_pkg::cmd_t    cmd
);

  fdfc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      fdfc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = fdfc_pkg::ST_SCAN;
        end
      end
      fdfc_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_next = fdfc_pkg::ST_FINISH;
        end
      end
      fdfc_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = fdfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fdfc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/fdfc_datapath.sv -----
// Datapath: stamp table scan (match and least entry), table update, result register.
// Depends on fdfc_pkg and fdfc_ram.
module fdfc_datapath #(
  parameter int TABLE_ENTRIES = fdfc_pkg::TABLE_ENTRIES_DEF,
  parameter int STAMP_BITS    = fdfc_pkg::STAMP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fdfc_pkg::cmd_t                  cmd,
  output fdfc_pkg::status_t               status,
  input  logic [fdfc_pkg::IN_W-1:0]       s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fdfc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [STAMP_BITS-1:0]    stamp_in;
  logic [STAMP_BITS-1:0]    stamp;
  logic                     issuing;
  logic [IDX_W-1:0]         rd_idx;
  logic                     cmp_en;
  logic [IDX_W-1:0]         cmp_idx;
  logic [STAMP_BITS-1:0]    rd_data;
  logic                     vld_q;
  logic [STAMP_BITS-1:0]    entry;
  logic [TABLE_ENTRIES-1:0] valid;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic [STAMP_BITS-1:0]    least;
  logic [IDX_W-1:0]         victim;
  logic [IDX_W-1:0]         sel_idx;
  logic [fdfc_pkg::SLOT_W-1:0] sel_slot;
  logic [fdfc_pkg::SLOT_W-1:0] slot;
  logic                     ram_we;

  generate
    if (STAMP_BITS > fdfc_pkg::IN_W) begin : g_stamp_ext
      assign stamp_in = {{(STAMP_BITS - fdfc_pkg::IN_W){1'b0}}, s_tdata};
    end else if (STAMP_BITS == fdfc_pkg::IN_W) begin : g_stamp_eq
      assign stamp_in = s_tdata;
    end else begin : g_stamp_cut
      assign stamp_in = s_tdata[STAMP_BITS-1:0];
    end

    if (IDX_W < fdfc_pkg::SLOT_W) begin : g_slot_ext
      assign sel_slot = {{(fdfc_pkg::SLOT_W - IDX_W){1'b0}}, sel_idx};
    end else if (IDX_W == fdfc_pkg::SLOT_W) begin : g_slot_eq
      assign sel_slot = sel_idx;
    end else begin : g_slot_cut
      assign sel_slot = sel_idx[fdfc_pkg::SLOT_W-1:0];
    end
  endgenerate

  assign ram_we  = cmd.finish && !hit;
  assign entry   = vld_q ? rd_data : '0;
  assign sel_idx = hit ? hit_idx : victim;

  fdfc_ram #(
    .WIDTH(STAMP_BITS),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(victim),
    .wdata(stamp),
    .re   (issuing),
    .raddr(rd_idx),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      stamp <= stamp_in;
    end
    if (issuing) begin
      vld_q <= valid[rd_idx];
    end
    cmp_idx <= rd_idx;
    if (cmd.start) begin
      rd_idx <= '0;
    end else if (issuing) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (cmd.start) begin
      hit <= 1'b0;
    end else if (cmp_en && !hit && entry == stamp) begin
      hit     <= 1'b1;
      hit_idx <= cmp_idx;
    end
    if (cmp_en && (cmp_idx == '0 || entry < least)) begin
      least  <= entry;
      victim <= cmp_idx;
    end
    if (cmd.finish) begin
      m_tuser <= !hit;
      slot    <= sel_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      cmp_en   <= 1'b0;
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      cmp_en <= issuing;
      if (cmd.start) begin
        issuing <= 1'b1;
      end else if (issuing && rd_idx == LAST_IDX) begin
        issuing <= 1'b0;
      end
      if (ram_we) begin
        valid[victim] <= 1'b1;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(fdfc_pkg::OUT_DATA_W - fdfc_pkg::SLOT_W){1'b0}}, slot};

  assign status.scan_done = cmp_en && cmp_idx == LAST_IDX;
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

// ----- sv/flood_duplicate_filter_cache.sv -----
// Flood duplicate filter cache, top level.
// Depends on fdfc_pkg, fdfc_ctrl, fdfc_datapath (and through it fdfc_ram).
//
// Usage:
//   Input stream (s_*): one transfer per received flood packet, s_tdata holds
//   its 32-bit timestamp. Output stream (m_*): one transfer per input,
//   m_tuser = forward flag (1 = new, rebroadcast; 0 = duplicate, drop),
//   m_tdata[3:0] = table slot that matched or was replaced.
//   Each packet runs a scan that reads the stamp table through its single
//   RAM read port, one entry per cycle, checking for a match and tracking
//   the least entry in the same pass; no new packet is taken until its
//   result is registered. The table write happens as the result is
//   registered.
//   The result sits in an output register; the next input is taken while it
//   waits. If the receiver stalls, a finished scan holds until the output
//   register frees.
//   Reset (rst, synchronous): clears all per-entry valid bits so the table
//   reads as all zero; no clearing pass is needed.
module flood_duplicate_filter_cache #(
  parameter int TABLE_ENTRIES = fdfc_pkg::TABLE_ENTRIES_DEF,
  parameter int STAMP_BITS    = fdfc_pkg::STAMP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fdfc_pkg::IN_W-1:0]       s_tdata,  // [31:0] packet_stamp
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fdfc_pkg::OUT_DATA_W-1:0] m_tdata,  // [3:0] slot, [7:4] zero
  output logic                            m_tuser   // [0] forward
);

  fdfc_pkg::cmd_t    cmd;
  fdfc_pkg::status_t status;

  fdfc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  fdfc_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .STAMP_BITS   (STAMP_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ----- sv/fdfc_checker.sv -----
// Port-level checker for the flood duplicate filter cache, bound to the top.
// Depends on fdfc_pkg and flood_duplicate_filter_cache.
module fdfc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [fdfc_pkg::IN_W-1:0]       s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fdfc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken during a scan");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared before the scan ran");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a scan in progress");

endmodule

bind flood_duplicate_filter_cache fdfc_checker u_fdfc_checker (.*);
